// ----- design/rmdf_pkg.sv -----
// Mode decision package: mode and reason codes, payload structs, helpers.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package rmdf_pkg;

  // Mode codes
  localparam logic [2:0] M_WAITHOME = 3'd0;
  localparam logic [2:0] M_WAITHP   = 3'd1;
  localparam logic [2:0] M_GOHOME   = 3'd2;
  localparam logic [2:0] M_GOCENTER = 3'd3;
  localparam logic [2:0] M_HOLD     = 3'd4;
  localparam logic [2:0] M_REPOS    = 3'd5;
  localparam logic [2:0] M_ENGAGE   = 3'd6;

  // Reason codes
  localparam logic [4:0] R_NONE           = 5'd0;
  localparam logic [4:0] R_GAME_INACTIVE  = 5'd1;
  localparam logic [4:0] R_HOME_INACTIVE  = 5'd2;
  localparam logic [4:0] R_LOW_HP_HOME    = 5'd3;
  localparam logic [4:0] R_RECOVERING     = 5'd4;
  localparam logic [4:0] R_HOME_FOR_HP    = 5'd5;
  localparam logic [4:0] R_LOW_HP         = 5'd6;
  localparam logic [4:0] R_RECOVERED      = 5'd7;
  localparam logic [4:0] R_WAIT_HP        = 5'd8;
  localparam logic [4:0] R_GAME_STARTED   = 5'd9;
  localparam logic [4:0] R_CENTER_REACHED = 5'd10;
  localparam logic [4:0] R_COMBAT_OFF     = 5'd11;
  localparam logic [4:0] R_HOLD_NO_COMBAT = 5'd12;
  localparam logic [4:0] R_SUPPRESSED     = 5'd13;
  localparam logic [4:0] R_REPOSITIONING  = 5'd14;
  localparam logic [4:0] R_REPOS_HOLD     = 5'd15;
  localparam logic [4:0] R_ENGAGE         = 5'd16;
  localparam logic [4:0] R_ENGAGING       = 5'd17;
  localparam logic [4:0] R_ENGAGE_HOLD    = 5'd18;
  localparam logic [4:0] R_CALM_HOLD      = 5'd19;
  localparam logic [4:0] R_HOLDING        = 5'd20;

  // Event and combat codes
  localparam logic [1:0] TGT_HOME      = 2'd0;
  localparam logic [1:0] TGT_CENTER    = 2'd1;
  localparam logic [1:0] EV_SUCCEEDED  = 2'd0;
  localparam logic [1:0] ENG_ENGAGING  = 2'd1;
  localparam logic [1:0] ENG_SUPPRESSED = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_HP_LOW      = 3'd0;
  localparam logic [2:0] CFG_HP_HIGH     = 3'd1;
  localparam logic [2:0] CFG_COMBAT_EN   = 3'd2;
  localparam logic [2:0] CFG_REPOS_GRACE = 3'd3;
  localparam logic [2:0] CFG_REPOS_HOLD  = 3'd4;
  localparam logic [2:0] CFG_ENGAGE_HOLD = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic        hp_valid;
    logic [15:0] hp_level;
    logic        match_running;
    logic        event_valid;
    logic [1:0]  event_target;
    logic [1:0]  event_kind;
    logic        combat_valid;
    logic [1:0]  engagement;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] prev_mode;
    logic [2:0] new_mode;
    logic       mode_changed;
    logic [4:0] reason_code;
    logic       recovering;
  } out_item_t;

  function automatic logic is_center(input logic [2:0] m);
    is_center = m inside {M_HOLD, M_REPOS, M_ENGAGE};
  endfunction

endpackage

// ----- design/rmdf_if.sv -----
// Valid/ready channel interfaces for decision ticks and decision results.
// Depends on rmdf_pkg for the payload structs.
`timescale 1ns / 1ps

interface rmdf_in_if import rmdf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmdf_out_if import rmdf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/robot_mode_decision_fsm.sv -----
// Robot mode decision block: one decision per tick, low-health hysteresis.
// Depends on rmdf_pkg and the channel interfaces in rmdf_if.sv.
//
// Usage:
//   in_ch carries one decision tick per transfer (health, game flag, executor
//   event, combat status, timestamp). out_ch carries one result per tick:
//   previous and new mode, changed flag, reason code and recovery flag.
//   cfg_we/cfg_idx/cfg_wdata write the thresholds, combat enable and the
//   hold/grace times; write them only while no tick is in flight.
// Result: registered on the input transfer, valid in the following cycle.
// Throughput: one tick per cycle while results are taken. The rule logic reads
//   the mode state and the tick directly and updates state and the result
//   register at once, so the next tick sees the updated mode.
// Stall: in_ch.ready is high while the result register is empty or being
//   taken; a stalled result holds and blocks only new ticks.
// Reset (rst_n low, synchronous): mode wait-home, recovery clear, entry time
//   zero, registers back to defaults, result register empty.
`timescale 1ns / 1ps

module robot_mode_decision_fsm import rmdf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rmdf_in_if.sink               in_ch,
  rmdf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] hp_low_r, hp_high_r, grace_r, repos_hold_r, engage_hold_r;
  logic        combat_en_r;

  logic [2:0]  mode_r, mode_nxt;
  logic        rec_r, rec_nxt;
  logic [31:0] ent_r, ent_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        acc;
  logic        home_ok, center_ok;
  logic [31:0] held;
  logic        repos_grace;
  logic        enter_center;
  logic [4:0]  reason;
  in_item_t    d;

  assign d            = in_ch.data;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign home_ok   = d.event_valid && d.event_target == TGT_HOME &&
                     d.event_kind == EV_SUCCEEDED;
  assign center_ok = d.event_valid && d.event_target == TGT_CENTER &&
                     d.event_kind == EV_SUCCEEDED;
  assign held        = d.now_ms - ent_r;
  assign repos_grace = mode_r == M_REPOS && held < {16'd0, grace_r};

  // Recovery hysteresis: clear test first, then set test
  always_comb begin
    rec_nxt = rec_r;
    if (d.hp_valid) begin
      if (rec_r && d.hp_level >= hp_high_r) begin
        rec_nxt = 1'b0;
      end else if (!rec_r && d.hp_level < hp_low_r) begin
        rec_nxt = 1'b1;
      end
    end
  end

  // Ordered rule chain
  always_comb begin
    mode_nxt = mode_r;
    reason   = R_NONE;
    if (!d.match_running) begin
      reason = R_GAME_INACTIVE;
      case (mode_r)
        M_WAITHOME: mode_nxt = M_WAITHOME;
        M_WAITHP:   mode_nxt = M_WAITHOME;
        M_GOHOME: begin
          if (home_ok) begin
            mode_nxt = M_WAITHOME;
            reason   = R_HOME_INACTIVE;
          end
        end
        default:    mode_nxt = M_GOHOME;
      endcase
    end else if (rec_nxt && mode_r == M_WAITHOME) begin
      mode_nxt = M_WAITHP;
      reason   = R_LOW_HP_HOME;
    end else if (rec_nxt && mode_r == M_WAITHP) begin
      reason = R_RECOVERING;
    end else if (rec_nxt && mode_r == M_GOHOME) begin
      if (home_ok) begin
        mode_nxt = M_WAITHP;
        reason   = R_HOME_FOR_HP;
      end else begin
        reason = R_RECOVERING;
      end
    end else if (rec_nxt && !repos_grace) begin
      mode_nxt = M_GOHOME;
      reason   = R_LOW_HP;
    end else if (mode_r == M_WAITHP || mode_r == M_GOHOME) begin
      mode_nxt = M_GOCENTER;
      reason   = R_RECOVERED;
    end else if (mode_r == M_WAITHOME) begin
      if (d.hp_valid) begin
        mode_nxt = M_GOCENTER;
        reason   = R_GAME_STARTED;
      end else begin
        reason = R_WAIT_HP;
      end
    end else if (mode_r == M_GOCENTER && center_ok) begin
      mode_nxt = M_HOLD;
      reason   = R_CENTER_REACHED;
    end else if (is_center(mode_r)) begin
      if (!combat_en_r || !d.combat_valid) begin
        mode_nxt = M_HOLD;
        reason   = (mode_r != M_HOLD) ? R_COMBAT_OFF : R_HOLD_NO_COMBAT;
      end else if (d.engagement == ENG_SUPPRESSED) begin
        mode_nxt = M_REPOS;
        reason   = (mode_r != M_REPOS) ? R_SUPPRESSED : R_REPOSITIONING;
      end else if (mode_r == M_REPOS && held < {16'd0, repos_hold_r}) begin
        reason = R_REPOS_HOLD;
      end else if (d.engagement == ENG_ENGAGING) begin
        mode_nxt = M_ENGAGE;
        reason   = (mode_r != M_ENGAGE) ? R_ENGAGE : R_ENGAGING;
      end else if (mode_r == M_ENGAGE && held < {16'd0, engage_hold_r}) begin
        reason = R_ENGAGE_HOLD;
      end else begin
        mode_nxt = M_HOLD;
        reason   = (mode_r != M_HOLD) ? R_CALM_HOLD : R_HOLDING;
      end
    end
  end

  assign enter_center = is_center(mode_nxt) && mode_nxt != mode_r;
  assign ent_nxt      = enter_center ? d.now_ms : ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_WAITHOME;
      rec_r       <= 1'b0;
      ent_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r      <= mode_nxt;
        rec_r       <= rec_nxt;
        ent_r       <= ent_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r.prev_mode    <= mode_r;
      out_data_r.new_mode     <= mode_nxt;
      out_data_r.mode_changed <= mode_nxt != mode_r;
      out_data_r.reason_code  <= reason;
      out_data_r.recovering   <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_low_r      <= 16'd100;
      hp_high_r     <= 16'd200;
      combat_en_r   <= 1'b1;
      grace_r       <= 16'd1000;
      repos_hold_r  <= 16'd1000;
      engage_hold_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HP_LOW:      hp_low_r      <= cfg_wdata;
        CFG_HP_HIGH:     hp_high_r     <= cfg_wdata;
        CFG_COMBAT_EN:   combat_en_r   <= cfg_wdata[0];
        CFG_REPOS_GRACE: grace_r       <= cfg_wdata;
        CFG_REPOS_HOLD:  repos_hold_r  <= cfg_wdata;
        CFG_ENGAGE_HOLD: engage_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result register follows the state it reports
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r && out_data_r.new_mode == mode_r &&
            out_data_r.recovering == rec_r)
    else $error("result does not match updated state");

  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.mode_changed ==
                    (out_data_r.prev_mode != out_data_r.new_mode))
    else $error("mode_changed inconsistent with modes");

  a_entry_time: assert property (@(posedge clk) disable iff (!rst_n)
    acc && enter_center |=> ent_r == $past(d.now_ms))
    else $error("center entry time not captured");

  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !d.hp_valid |=> rec_r == $past(rec_r))
    else $error("recovery flag changed without health reading");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !acc && !out_ch.ready |=> $stable(mode_r) && $stable(ent_r))
    else $error("state moved without a transfer");

endmodule
